// ===== design/wlc_pkg.sv =====
// Shared types and constants for the word list censor.
`timescale 1ns / 1ps
package wlc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WORDS_IN_USE = 3'd0;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PERIOD  = 8'd46;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'd44;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_MASK    = 8'd88;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_READ,
        ST_LOAD,
        ST_SPACE,
        ST_NEWLINE
    } t_state;

    typedef enum logic [1:0] {
        OUT_WORD,
        OUT_SPACE,
        OUT_NEWLINE
    } t_out_sel;

    typedef struct packed {
        logic     store_char;
        logic     clear_word;
        logic     match_start;
        logic     match_step;
        logic     emit_start;
        logic     emit_next;
        logic     load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic char_zero;
        logic char_delim;
        logic match_done;
        logic emit_done;
        logic out_free;
    } t_status;

endpackage

// ===== design/wlc_datapath.sv =====
// Datapath of the word list censor: word buffer, blocked word list, matcher and output register.
`timescale 1ns / 1ps
module wlc_datapath #(
    parameter int WORD_MAX   = 40,
    parameter int LIST_WORDS = 7,
    parameter int LIST_CHARS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [wlc_pkg::CHAR_W-1:0]         i_char,
    input  logic                               i_cfg_we,
    input  logic [wlc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wlc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wlc_pkg::t_cmd                      i_cmd,
    output wlc_pkg::t_status                   o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [wlc_pkg::CHAR_W-1:0]         o_out_char,
    output logic                               o_out_last
);

    localparam int LEN_W  = $clog2(WORD_MAX + 1);
    localparam int ADDR_W = $clog2(WORD_MAX);
    localparam int FW     = $clog2(LIST_WORDS + 1);
    localparam int NWORDS = 2 ** FW;

    logic [wlc_pkg::CHAR_W-1:0]     r_mem [WORD_MAX];
    logic [wlc_pkg::CHAR_W-1:0]     r_head [LIST_CHARS];
    logic [wlc_pkg::CFG_DATA_W-1:0] r_blocked [NWORDS];
    logic [wlc_pkg::COUNT_W-1:0]    r_words_in_use;
    logic [LEN_W-1:0]               r_len;
    logic [LEN_W-1:0]               r_k;
    logic [FW-1:0]                  r_f;
    logic                           r_hit;
    logic [wlc_pkg::CHAR_W-1:0]     r_rd_data;
    logic                           r_out_valid;
    logic [wlc_pkg::CHAR_W-1:0]     r_out_char;
    logic                           r_out_last;

    logic [wlc_pkg::COUNT_W-1:0]    limit;
    logic                           word_eq;
    logic                           out_free;
    logic [wlc_pkg::CHAR_W-1:0]     n_out_char;
    logic                           n_out_last;

    assign limit = (r_words_in_use > wlc_pkg::COUNT_W'(LIST_WORDS)) ?
                   wlc_pkg::COUNT_W'(LIST_WORDS) : r_words_in_use;
    assign out_free = !r_out_valid || i_out_ready;

    // Exact compare of the gathered word with the blocked word at r_f.
    always_comb begin
        logic [wlc_pkg::CFG_DATA_W-1:0] w;
        logic [wlc_pkg::CHAR_W-1:0]     b;
        logic                           alive;
        logic                           ok;
        logic [LEN_W-1:0]               n;
        w     = r_blocked[r_f];
        alive = 1'b1;
        ok    = 1'b1;
        n     = '0;
        for (int j = 0; j < LIST_CHARS; j++) begin
            b = w[j*wlc_pkg::CHAR_W +: wlc_pkg::CHAR_W];
            if (alive) begin
                if (b == wlc_pkg::CH_NUL) begin
                    alive = 1'b0;
                end else begin
                    n = n + LEN_W'(1);
                    if (b != r_head[j]) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        word_eq = ok && (n == r_len);
    end

    always_comb begin
        o_status.char_zero  = (i_char == wlc_pkg::CH_NUL);
        o_status.char_delim = (i_char == wlc_pkg::CH_SPACE) ||
                              (i_char == wlc_pkg::CH_PERIOD) ||
                              (i_char == wlc_pkg::CH_COMMA);
        o_status.match_done = (wlc_pkg::COUNT_W'(r_f) >= limit);
        o_status.emit_done  = (r_k == r_len);
        o_status.out_free   = out_free;
    end

    always_comb begin
        unique case (i_cmd.out_sel)
            wlc_pkg::OUT_WORD: begin
                n_out_char = r_hit ? wlc_pkg::CH_MASK : r_rd_data;
                n_out_last = 1'b0;
            end
            wlc_pkg::OUT_SPACE: begin
                n_out_char = wlc_pkg::CH_SPACE;
                n_out_last = 1'b1;
            end
            wlc_pkg::OUT_NEWLINE: begin
                n_out_char = wlc_pkg::CH_NEWLINE;
                n_out_last = 1'b1;
            end
            default: begin
                n_out_char = wlc_pkg::CH_NEWLINE;
                n_out_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_char && (r_len < LEN_W'(WORD_MAX))) begin
            r_mem[r_len[ADDR_W-1:0]] <= i_char;
        end
        r_rd_data <= r_mem[r_k[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LIST_CHARS; j++) begin
            if (i_cmd.store_char && (r_len == LEN_W'(j))) begin
                r_head[j] <= i_char;
            end
        end
        if (i_cmd.load) begin
            r_out_char <= n_out_char;
            r_out_last <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_in_use <= '0;
            for (int i = 0; i < NWORDS; i++) begin
                r_blocked[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == wlc_pkg::REG_WORDS_IN_USE) begin
                r_words_in_use <= i_cfg_data[wlc_pkg::COUNT_W-1:0];
            end else if ((i_cfg_index - wlc_pkg::CFG_IDX_W'(1)) <
                         wlc_pkg::CFG_IDX_W'(LIST_WORDS)) begin
                r_blocked[FW'(i_cfg_index - wlc_pkg::CFG_IDX_W'(1))] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_k         <= '0;
            r_f         <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_word) begin
                r_len <= '0;
            end else if (i_cmd.store_char && (r_len < LEN_W'(WORD_MAX))) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (i_cmd.match_start) begin
                r_f   <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.match_step) begin
                r_f   <= r_f + FW'(1);
                r_hit <= r_hit | word_eq;
            end
            if (i_cmd.emit_start) begin
                r_k <= '0;
            end else if (i_cmd.emit_next) begin
                r_k <= r_k + LEN_W'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// ===== design/wlc_ctrl.sv =====
// Controller state machine of the word list censor.
`timescale 1ns / 1ps
module wlc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wlc_pkg::t_status  i_status,
    output wlc_pkg::t_cmd     o_cmd
);

    wlc_pkg::t_state r_state;
    wlc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.out_sel = wlc_pkg::OUT_WORD;
        unique case (r_state)
            wlc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    priority if (i_status.char_zero) begin
                        o_cmd.clear_word = 1'b1;
                        n_state = wlc_pkg::ST_NEWLINE;
                    end else if (i_status.char_delim) begin
                        o_cmd.match_start = 1'b1;
                        n_state = wlc_pkg::ST_MATCH;
                    end else begin
                        o_cmd.store_char = 1'b1;
                    end
                end
            end
            wlc_pkg::ST_MATCH: begin
                if (i_status.match_done) begin
                    o_cmd.emit_start = 1'b1;
                    n_state = wlc_pkg::ST_READ;
                end else begin
                    o_cmd.match_step = 1'b1;
                end
            end
            wlc_pkg::ST_READ: begin
                if (i_status.emit_done) begin
                    n_state = wlc_pkg::ST_SPACE;
                end else begin
                    n_state = wlc_pkg::ST_LOAD;
                end
            end
            wlc_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.out_sel   = wlc_pkg::OUT_WORD;
                    o_cmd.emit_next = 1'b1;
                    n_state = wlc_pkg::ST_READ;
                end
            end
            wlc_pkg::ST_SPACE: begin
                if (i_status.out_free) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.out_sel    = wlc_pkg::OUT_SPACE;
                    o_cmd.clear_word = 1'b1;
                    n_state = wlc_pkg::ST_IDLE;
                end
            end
            wlc_pkg::ST_NEWLINE: begin
                if (i_status.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.out_sel = wlc_pkg::OUT_NEWLINE;
                    n_state = wlc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wlc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/word_list_censor_core.sv =====
// Top level of the word list censor.
`timescale 1ns / 1ps
// Text characters arrive as items on the slave stream, one per item. Other characters are
// gathered into a word buffer; a space, period or comma ends the word, which is
// then compared with the enabled blocked words. The master stream then carries
// the word, or one 'X' per character on a match, followed by a space with tlast
// set. A zero character emits a newline with tlast set and drops the pending word.
// Blocked words and their count are written on the configuration channel, which
// is always ready; register 0 is the count, registers 1 to 7 the words.
// A word character is taken while the block is idle. A delimiter starts the matcher,
// which steps through each enabled blocked word; then each emitted character takes a
// buffer memory read, then an output load, and a last read and the space follow;
// the next item is taken after that. A zero character loads the newline before the
// next item is taken.
// The output register lets one finished item wait while the block goes on; when
// the receiver stalls, emission pauses in place.
// Reset clears the word, the count and the blocked words and empties the output.
module word_list_censor_core #(
    parameter int WORD_MAX   = 40,
    parameter int LIST_WORDS = 7,
    parameter int LIST_CHARS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,    // [7:0] in_char
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,    // [7:0] out_char
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wlc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wlc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wlc_pkg::t_cmd    cmd;
    wlc_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    wlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wlc_datapath #(
        .WORD_MAX   (WORD_MAX),
        .LIST_WORDS (LIST_WORDS),
        .LIST_CHARS (LIST_CHARS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_char  (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

endmodule

// ===== bench/tb_word_list_censor_core.sv =====
// Self-checking testbench for the word list censor: random text, blocked-word setups and flow control.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} t_censored_char;

class censor_scoreboard #(
    int WORD_MAX   = 40,
    int LIST_WORDS = 7,
    int LIST_CHARS = 8
);
    logic [7:0]     word_buf [WORD_MAX];
    int             word_len;
    logic [2:0]     words_in_use;
    logic [63:0]    blocked [LIST_WORDS];
    t_censored_char expected_q [$];
    int             errors;
    int             words_masked;
    int             words_passed;
    int             message_ends;
    int             chars_dropped;
    int             results_checked;

    function new();
        clear_word();
        words_in_use = '0;
        foreach (blocked[i]) blocked[i] = '0;
        errors = 0;
        words_masked = 0;
        words_passed = 0;
        message_ends = 0;
        chars_dropped = 0;
        results_checked = 0;
    endfunction

    function void clear_word();
        foreach (word_buf[i]) word_buf[i] = '0;
        word_len = 0;
    endfunction

    function void write_reg(logic [wlc_pkg::CFG_IDX_W-1:0] idx,
                            logic [wlc_pkg::CFG_DATA_W-1:0] val);
        if (idx == wlc_pkg::REG_WORDS_IN_USE) begin
            words_in_use = val[wlc_pkg::COUNT_W-1:0];
        end else if (idx <= LIST_WORDS) begin
            blocked[idx - 1] = val;
        end
    endfunction

    function bit word_equals(logic [63:0] w);
        int n;
        n = 0;
        while (n < LIST_CHARS && w[8*n +: 8] != 8'd0) n++;
        if (n != word_len) return 1'b0;
        for (int k = 0; k < n; k++) begin
            if (w[8*k +: 8] != word_buf[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void expect_char(logic [7:0] ch, logic last);
        t_censored_char e;
        e.ch = ch;
        e.last = last;
        expected_q.push_back(e);
    endfunction

    // Works out the output items that one accepted character causes.
    function void note_char(logic [7:0] ch);
        int  limit;
        bit  hit;
        if (ch == wlc_pkg::CH_NUL) begin
            clear_word();
            expect_char(wlc_pkg::CH_NEWLINE, 1'b1);
            message_ends++;
            return;
        end
        if (ch != wlc_pkg::CH_SPACE && ch != wlc_pkg::CH_PERIOD &&
            ch != wlc_pkg::CH_COMMA) begin
            if (word_len < WORD_MAX) begin
                word_buf[word_len] = ch;
                word_len++;
            end else begin
                chars_dropped++;
            end
            return;
        end
        limit = (words_in_use > LIST_WORDS) ? LIST_WORDS : words_in_use;
        hit = 1'b0;
        for (int f = 0; f < limit; f++) begin
            if (word_equals(blocked[f])) hit = 1'b1;
        end
        for (int k = 0; k < word_len; k++) begin
            expect_char(hit ? wlc_pkg::CH_MASK : word_buf[k], 1'b0);
        end
        expect_char(wlc_pkg::CH_SPACE, 1'b1);
        if (hit) words_masked++;
        else words_passed++;
        clear_word();
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic [7:0] ch, logic last);
        t_censored_char e;
        results_checked++;
        if (expected_q.size() == 0) begin
            report($sformatf("output item char=%02h last=%0b with nothing expected",
                             ch, last));
            return;
        end
        e = expected_q.pop_front();
        if (ch != e.ch) begin
            report($sformatf("out_char %02h, expected %02h", ch, e.ch));
        end
        if (last != e.last) begin
            report($sformatf("run_end %0b, expected %0b (char %02h)", last, e.last, e.ch));
        end
    endtask
endclass

module tb_word_list_censor_core;

    localparam int WORD_MAX    = 40;
    localparam int LIST_WORDS  = 7;
    localparam int LIST_CHARS  = 8;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 68;
    localparam int IDLE_GAP    = 16;
    localparam int END_GAP     = 120;

    localparam logic [wlc_pkg::CFG_IDX_W-1:0] REG_BLOCKED_1 = 3'd1;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_STALLS
    } t_rx_mode;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [7:0]                     i_s_tdata   = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [7:0]                     o_m_tdata;
    logic                           o_m_tlast;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [wlc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [wlc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    censor_scoreboard #(WORD_MAX, LIST_WORDS, LIST_CHARS) sb;

    logic [2:0]  cfg_count;
    logic [63:0] cfg_words [LIST_WORDS];
    logic [7:0]  word_chars [$];
    int          items_sent;
    int          burst_left;
    t_rx_mode    rx_mode;
    int          rx_span;
    int          rx_hold;

    word_list_censor_core #(
        .WORD_MAX  (WORD_MAX),
        .LIST_WORDS(LIST_WORDS),
        .LIST_CHARS(LIST_CHARS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready) sb.note_char(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tlast);
        end
    end

    // The receiver switches between always ready, coin-flip ready and bursts of stalls.
    initial begin
        rx_mode = RX_STEADY;
        rx_span = 0;
        rx_hold = 0;
    end

    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_span = $urandom_range(64, 256);
        end else begin
            rx_span--;
        end
        case (rx_mode)
            RX_STEADY: begin
                i_m_tready <= 1'b1;
            end
            RX_COIN: begin
                i_m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_hold == 0 && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 10);
                if (rx_hold != 0) begin
                    rx_hold--;
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        endcase
    end

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == wlc_pkg::CH_SPACE || c == wlc_pkg::CH_PERIOD ||
                   c == wlc_pkg::CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 2))
            0: return wlc_pkg::CH_SPACE;
            1: return wlc_pkg::CH_PERIOD;
            default: return wlc_pkg::CH_COMMA;
        endcase
    endfunction

    function automatic logic [63:0] pack_word(string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < LIST_CHARS; i++) w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic logic [63:0] make_blocked(int kind);
        logic [63:0] w;
        int          n;
        w = '0;
        case (kind)
            0: begin
                w = '0;
            end
            2: begin
                w = {$urandom, $urandom};
            end
            default: begin
                n = (kind == 3) ? LIST_CHARS : $urandom_range(1, LIST_CHARS - 1);
                for (int i = 0; i < n; i++) w[8*i +: 8] = plain_char();
            end
        endcase
        return w;
    endfunction

    task automatic write_reg(logic [wlc_pkg::CFG_IDX_W-1:0] idx,
                             logic [wlc_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == wlc_pkg::REG_WORDS_IN_USE) cfg_count = val[wlc_pkg::COUNT_W-1:0];
        else cfg_words[idx - REG_BLOCKED_1] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic put_char(logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic setup_phase(int phase);
        logic [63:0] w;
        for (int i = 0; i < LIST_WORDS; i++) begin
            case (phase)
                0: begin
                    w = (i == 6) ? 64'd0 :
                        (i == 2) ? cfg_words[0] : make_blocked($urandom_range(1, 3));
                end
                3: begin
                    w = (i == 6) ? '1 : make_blocked($urandom_range(2, 3));
                end
                default: begin
                    w = make_blocked($urandom_range(0, 3));
                end
            endcase
            write_reg(REG_BLOCKED_1 + wlc_pkg::CFG_IDX_W'(i), w);
        end
        case (phase)
            0, 3: write_reg(wlc_pkg::REG_WORDS_IN_USE, 64'd7);
            1: write_reg(wlc_pkg::REG_WORDS_IN_USE, 64'd0);
            default: write_reg(wlc_pkg::REG_WORDS_IN_USE, 64'($urandom_range(0, 7)));
        endcase
    endtask

    // Mostly whole words, many of them blocked words or near misses, with noise mixed in.
    task automatic run_phase(int count);
        int stop_at;
        int r;
        int len;
        int f;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                word_chars.delete();
                if (cfg_count != 0 && $urandom_range(0, 1) == 1) begin
                    f = $urandom_range(0, cfg_count - 1);
                    for (int k = 0; k < LIST_CHARS; k++) begin
                        if (cfg_words[f][8*k +: 8] == 8'd0) break;
                        word_chars.push_back(cfg_words[f][8*k +: 8]);
                    end
                    case ($urandom_range(0, 5))
                        0: if (word_chars.size() != 0) void'(word_chars.pop_back());
                        1: word_chars.push_back(plain_char());
                        default: ;
                    endcase
                end else begin
                    len = ($urandom_range(0, 11) == 0) ? $urandom_range(36, 46)
                                                       : $urandom_range(0, 8);
                    repeat (len) word_chars.push_back(plain_char());
                end
                foreach (word_chars[i]) put_char(word_chars[i]);
                put_char(($urandom_range(0, 9) == 0) ? wlc_pkg::CH_NUL : pick_delim());
            end else if (r < 84) begin
                put_char(8'($urandom_range(0, 255)));
            end else if (r < 88) begin
                drain();
            end else begin
                repeat ($urandom_range(1, 6)) put_char(plain_char());
                put_char(wlc_pkg::CH_NUL);
            end
        end
    endtask

    initial begin
        sb = new();
        cfg_count = '0;
        foreach (cfg_words[i]) cfg_words[i] = '0;
        items_sent = 0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_BLOCKED_1, pack_word("cat"));
        write_reg(REG_BLOCKED_1 + 3'd1, pack_word("dog"));
        write_reg(REG_BLOCKED_1 + 3'd2, pack_word("abcdefgh"));
        write_reg(wlc_pkg::REG_WORDS_IN_USE, 64'd3);
        send_text("cat ");
        send_text("cats,");
        send_text("ca.");
        send_text(" ");
        send_text("abcdefgh.");
        put_char(8'hFF);
        put_char(8'h01);
        put_char(wlc_pkg::CH_NUL);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            setup_phase(phase);
            run_phase(PHASE_ITEMS);
            drain();
        end
        repeat (END_GAP) @(posedge i_clk);

        $display("Sent %0d characters over %0d blocked-word setups; %0d output items checked.",
                 items_sent, PHASES + 1, sb.results_checked);
        $display("Words masked %0d, passed %0d; message ends %0d; overflow characters %0d.",
                 sb.words_masked, sb.words_passed, sb.message_ends, sb.chars_dropped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timed out with %0d output items still expected.", sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
